[src/rbsi_pkg.sv]
// Shared types and constants of the ray/box slab intersection core.
// Holds the ray and result payload structs and the register indexes.
// No dependencies.
`default_nettype none

package rbsi_pkg;

	localparam int DATA_W        = 32;
	localparam int HALF_W        = 31;
	// Slab numerator center +/- half - origin, two's complement.
	localparam int NUM_W         = 34;
	// Magnitude of that numerator.
	localparam int NMAG_W        = 33;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_AXES      = 3;
	localparam int CFG_IDX_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd5;

	localparam logic [HALF_W-1:0] HALF_RESET = 31'd65536;

	typedef struct packed {
		logic signed [DATA_W-1:0] origin_x;
		logic signed [DATA_W-1:0] origin_y;
		logic signed [DATA_W-1:0] origin_z;
		logic signed [DATA_W-1:0] dir_x;
		logic signed [DATA_W-1:0] dir_y;
		logic signed [DATA_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] point_x;
		logic signed [DATA_W-1:0] point_y;
		logic signed [DATA_W-1:0] point_z;
	} result_t;

	// Per-axis ray data carried alongside the divider and reduction stages.
	typedef struct packed {
		logic [NUM_AXES-1:0][DATA_W-1:0] org;
		logic [NUM_AXES-1:0][DATA_W-1:0] dmag;
		logic [NUM_AXES-1:0]             dneg;
	} axis_data_t;

	// Side data that travels in step with the dividers.
	typedef struct packed {
		logic                zmiss;
		logic [NUM_AXES-1:0] act;
		axis_data_t          axd;
	} side_t;

endpackage

`default_nettype wire

[src/rbsi_div.sv]
// Pipelined signed divider: (num << FRAC_BITS) / dir, truncated toward zero.
// One quotient bit per stage, between an entry stage and a sign stage.
// Depends on rbsi_pkg.
`default_nettype none

module rbsi_div #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                              clk,
	input  wire logic [rbsi_pkg::NUM_W-1:0]                        num,
	input  wire logic [rbsi_pkg::DATA_W-1:0]                       dmag,
	input  wire logic                                              dneg,
	output logic      [rbsi_pkg::NMAG_W+FRAC_BITS:0]               quo
);
	import rbsi_pkg::*;

	localparam int BW = NMAG_W + FRAC_BITS;

	logic [NUM_W-1:0]  num_abs;
	logic [BW-1:0]     nq_s  [BW+1];
	logic [DATA_W-1:0] rem_s [BW];
	logic [DATA_W-1:0] d_s   [BW];
	logic [BW:0]       neg_s;

	// Entry stage: magnitudes and the quotient sign.
	assign num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;

	always_ff @(posedge clk) begin
		nq_s[0]  <= {num_abs[NMAG_W-1:0], {FRAC_BITS{1'b0}}};
		rem_s[0] <= '0;
		d_s[0]   <= dmag;
		neg_s[0] <= num[NUM_W-1] ^ dneg;
	end

	// Restoring division, one bit of the shifted dividend per stage.
	for (genvar k = 0; k < BW; k++) begin : g_step
		logic [DATA_W:0] trial;
		logic [DATA_W:0] diff;
		logic            ge;

		assign trial = {rem_s[k], nq_s[k][BW-1]};
		assign diff  = trial - {1'b0, d_s[k]};
		assign ge    = (trial >= {1'b0, d_s[k]});

		always_ff @(posedge clk) begin
			nq_s[k+1]  <= {nq_s[k][BW-2:0], ge};
			neg_s[k+1] <= neg_s[k];
		end

		if (k < BW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				d_s[k+1]   <= d_s[k];
			end
		end
	end

	// Apply the sign to the quotient magnitude.
	always_ff @(posedge clk) begin
		quo <= neg_s[BW] ? (~{1'b0, nq_s[BW]} + 1'b1) : {1'b0, nq_s[BW]};
	end

endmodule

`default_nettype wire

[src/rbsi_reduce.sv]
// Slab reduction: largest entry, smallest exit, hit decision and t select.
// Two register stages; carries the per-axis ray data along.
// Depends on rbsi_pkg.
`default_nettype none

module rbsi_reduce #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic                                                  in_vld,
	input  wire logic [rbsi_pkg::NUM_AXES-1:0][rbsi_pkg::NMAG_W+FRAC_BITS:0] t_lo,
	input  wire logic [rbsi_pkg::NUM_AXES-1:0][rbsi_pkg::NMAG_W+FRAC_BITS:0] t_hi,
	input  wire rbsi_pkg::side_t                                       side,
	output logic                                                       out_vld,
	output logic                                                       hit,
	output logic      [rbsi_pkg::NMAG_W+FRAC_BITS-1:0]                 t,
	output rbsi_pkg::axis_data_t                                       axd
);
	import rbsi_pkg::*;

	localparam int BW = NMAG_W + FRAC_BITS;
	localparam int TW = BW + 1;

	logic [NUM_AXES-1:0][TW-1:0] ent;
	logic [NUM_AXES-1:0][TW-1:0] ext;
	logic [TW-1:0]               emax;
	logic [TW-1:0]               emin;
	logic                        any_c;

	logic                        vld_s1;
	logic                        any_s1;
	logic                        zmiss_s1;
	logic [TW-1:0]               ent_s1;
	logic [TW-1:0]               ext_s1;
	axis_data_t                  axd_s1;

	logic                        ok_c;
	logic [TW-1:0]               tsel_c;

	// Order each slab by the direction sign, then fold over active axes.
	always_comb begin
		any_c = 1'b0;
		emax  = '0;
		emin  = '0;
		for (int a = 0; a < NUM_AXES; a++) begin
			ent[a] = side.axd.dneg[a] ? t_hi[a] : t_lo[a];
			ext[a] = side.axd.dneg[a] ? t_lo[a] : t_hi[a];
			if (side.act[a] && (!any_c || ($signed(ent[a]) > $signed(emax)))) begin
				emax = ent[a];
			end
			if (side.act[a] && (!any_c || ($signed(ext[a]) < $signed(emin)))) begin
				emin = ext[a];
			end
			any_c = any_c | side.act[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		any_s1   <= any_c;
		zmiss_s1 <= side.zmiss;
		ent_s1   <= emax;
		ext_s1   <= emin;
		axd_s1   <= side.axd;
	end

	// Hit needs exit beyond entry and exit not behind the origin.
	assign ok_c = !zmiss_s1 &&
		(!any_s1 || (($signed(ext_s1) > $signed(ent_s1)) && !ext_s1[TW-1]));
	assign tsel_c = !any_s1 ? '0 : (ent_s1[TW-1] ? ext_s1 : ent_s1);

	always_ff @(posedge clk) begin
		hit <= ok_c;
		t   <= tsel_c[BW-1:0];
		axd <= axd_s1;
	end

endmodule

`default_nettype wire

[src/rbsi_point.sv]
// Hit point of one axis: origin + (dir * t) >> FRAC_BITS, saturated.
// Three register stages: split multiply, sum and clamp, add and saturate.
// Depends on rbsi_pkg.
`default_nettype none

module rbsi_point #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  hit,
	input  wire logic [rbsi_pkg::NMAG_W+FRAC_BITS-1:0] t,
	input  wire logic [rbsi_pkg::DATA_W-1:0]           org,
	input  wire logic [rbsi_pkg::DATA_W-1:0]           dmag,
	input  wire logic                                  dneg,
	output logic      [rbsi_pkg::DATA_W-1:0]           point
);
	import rbsi_pkg::*;

	localparam int BW    = NMAG_W + FRAC_BITS;
	localparam int HW    = BW - DATA_W;
	localparam int PW    = DATA_W + BW;
	localparam int MAG_W = NMAG_W + 1;
	localparam int SW    = MAG_W + 1;

	logic [2*DATA_W-1:0]  plo_s1;
	logic [DATA_W+HW-1:0] phi_s1;
	logic                 neg_s1;
	logic [DATA_W-1:0]    org_s1;
	logic                 hit_s1;

	logic [PW-1:0]        sum_c;
	logic                 ovf_c;
	logic [MAG_W-1:0]     mag_s2;
	logic                 neg_s2;
	logic [DATA_W-1:0]    org_s2;
	logic                 hit_s2;

	logic [SW-1:0]        smag_c;
	logic [SW-1:0]        pos_c;
	logic                 sat_c;

	// Stage 1: two partial products of at most 32 by 32 bits.
	always_ff @(posedge clk) begin
		plo_s1 <= dmag * t[DATA_W-1:0];
		phi_s1 <= dmag * t[BW-1:DATA_W];
		neg_s1 <= dneg;
		org_s1 <= org;
		hit_s1 <= hit;
	end

	// Stage 2: full product, scaled and clamped to 2^33.
	assign sum_c = {phi_s1, {DATA_W{1'b0}}} + {{(PW-2*DATA_W){1'b0}}, plo_s1};
	assign ovf_c = |sum_c[PW-1:BW];

	always_ff @(posedge clk) begin
		mag_s2 <= ovf_c ? {1'b1, {(MAG_W-1){1'b0}}} : {1'b0, sum_c[BW-1:FRAC_BITS]};
		neg_s2 <= neg_s1;
		org_s2 <= org_s1;
		hit_s2 <= hit_s1;
	end

	// Stage 3: add to the origin and saturate to 32 bits; zero on a miss.
	assign smag_c = neg_s2 ? (~{1'b0, mag_s2} + 1'b1) : {1'b0, mag_s2};
	assign pos_c  = {{(SW-DATA_W){org_s2[DATA_W-1]}}, org_s2} + smag_c;
	assign sat_c  = (pos_c[SW-1:DATA_W-1] != {(SW-DATA_W+1){pos_c[SW-1]}});

	always_ff @(posedge clk) begin
		if (!hit_s2) begin
			point <= '0;
		end else if (sat_c) begin
			point <= {pos_c[SW-1], {(DATA_W-1){~pos_c[SW-1]}}};
		end else begin
			point <= pos_c[DATA_W-1:0];
		end
	end

endmodule

`default_nettype wire

[src/ray_box_slab_intersect_core.sv]
// Ray against axis-aligned box slab test, Q16.16 fixed point by default.
// Top level; instantiates rbsi_div, rbsi_reduce and rbsi_point; uses rbsi_pkg.
//
// Usage:
//   Rays arrive on ray with start; a transfer happens at each clock edge
//   where start is high and busy is low. busy stays low, so a ray can be
//   issued on every cycle, one ray per cycle sustained.
//   Each ray gives one result on result, marked by done for one cycle,
//   after the input register, the divider pipeline, the reduction stages
//   and the point stages. The divider pipeline resolves one quotient bit
//   of each slab distance per stage (FRAC_BITS + 33 stages).
//   Results leave in issue order; the receiver has no stall and must take
//   each result in the cycle that done is high.
//   The box center and half-extents are written through cfg_valid/cfg_addr/
//   cfg_wdata; cfg_ready is always high. Write them only while no ray is
//   in flight.
//   Reset clears all valid bits in the pipeline, sets the center to zero
//   and each half-extent to 65536 (1.0 at FRAC_BITS = 16).
`default_nettype none

module ray_box_slab_intersect_core #(
	parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire rbsi_pkg::ray_t                   ray,
	output logic                                  done,
	output rbsi_pkg::result_t                     result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rbsi_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [rbsi_pkg::DATA_W-1:0]      cfg_wdata
);
	import rbsi_pkg::*;

	localparam int BW      = NMAG_W + FRAC_BITS;
	localparam int TW      = BW + 1;
	localparam int DIV_LAT = BW + 2;
	// Edges from the ray transfer to the edge that takes its result.
	localparam int LAT     = DIV_LAT + 6;

	logic [DATA_W-1:0]  center_q [NUM_AXES];
	logic [HALF_W-1:0]  half_q   [NUM_AXES];

	logic [DATA_W-1:0]  org_in [NUM_AXES];
	logic [DATA_W-1:0]  dir_in [NUM_AXES];
	logic [NUM_W-1:0]   lo_c   [NUM_AXES];
	logic [NUM_W-1:0]   hi_c   [NUM_AXES];

	logic                        vld_s1;
	logic [NUM_W-1:0]            lo_s1 [NUM_AXES];
	logic [NUM_W-1:0]            hi_s1 [NUM_AXES];
	logic [NUM_AXES-1:0]         dzero_s1;
	axis_data_t                  axd_s1;
	logic                        zmiss_c;

	side_t                       side_s [DIV_LAT];
	logic [DIV_LAT-1:0]          vld_d;
	logic [NUM_AXES-1:0][TW-1:0] t_lo;
	logic [NUM_AXES-1:0][TW-1:0] t_hi;

	logic                        red_vld;
	logic                        red_hit;
	logic [BW-1:0]               red_t;
	axis_data_t                  red_axd;

	logic [DATA_W-1:0]           pt [NUM_AXES];
	logic [2:0]                  vld_p;
	logic [2:0]                  hit_p;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Box registers, written by configuration transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				center_q[a] <= '0;
				half_q[a]   <= HALF_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				REG_CENTER_X: center_q[0] <= cfg_wdata;
				REG_CENTER_Y: center_q[1] <= cfg_wdata;
				REG_CENTER_Z: center_q[2] <= cfg_wdata;
				REG_HALF_X:   half_q[0]   <= cfg_wdata[HALF_W-1:0];
				REG_HALF_Y:   half_q[1]   <= cfg_wdata[HALF_W-1:0];
				REG_HALF_Z:   half_q[2]   <= cfg_wdata[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	assign org_in[0] = ray.origin_x;
	assign org_in[1] = ray.origin_y;
	assign org_in[2] = ray.origin_z;
	assign dir_in[0] = ray.dir_x;
	assign dir_in[1] = ray.dir_y;
	assign dir_in[2] = ray.dir_z;

	// Slab numerators relative to the ray origin.
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			lo_c[a] = {{(NUM_W-DATA_W){center_q[a][DATA_W-1]}}, center_q[a]}
				- {{(NUM_W-HALF_W){1'b0}}, half_q[a]}
				- {{(NUM_W-DATA_W){org_in[a][DATA_W-1]}}, org_in[a]};
			hi_c[a] = {{(NUM_W-DATA_W){center_q[a][DATA_W-1]}}, center_q[a]}
				+ {{(NUM_W-HALF_W){1'b0}}, half_q[a]}
				- {{(NUM_W-DATA_W){org_in[a][DATA_W-1]}}, org_in[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NUM_AXES; a++) begin
			lo_s1[a]        <= lo_c[a];
			hi_s1[a]        <= hi_c[a];
			dzero_s1[a]     <= (dir_in[a] == '0);
			axd_s1.org[a]   <= org_in[a];
			axd_s1.dmag[a]  <= dir_in[a][DATA_W-1] ? (~dir_in[a] + 1'b1) : dir_in[a];
			axd_s1.dneg[a]  <= dir_in[a][DATA_W-1];
		end
	end

	// An axis with zero direction misses when the origin is outside its slab.
	always_comb begin
		zmiss_c = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (dzero_s1[a] && ((!lo_s1[a][NUM_W-1] && (lo_s1[a] != '0))
				|| hi_s1[a][NUM_W-1])) begin
				zmiss_c = 1'b1;
			end
		end
	end

	// Side data delay line, matched to the divider latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d <= '0;
		end else begin
			vld_d <= {vld_d[DIV_LAT-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0].zmiss <= zmiss_c;
		side_s[0].act   <= ~dzero_s1;
		side_s[0].axd   <= axd_s1;
		for (int k = 1; k < DIV_LAT; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// Entry and exit distances of each slab.
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
			.clk  (clk),
			.num  (lo_s1[a]),
			.dmag (axd_s1.dmag[a]),
			.dneg (axd_s1.dneg[a]),
			.quo  (t_lo[a])
		);

		rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
			.clk  (clk),
			.num  (hi_s1[a]),
			.dmag (axd_s1.dmag[a]),
			.dneg (axd_s1.dneg[a]),
			.quo  (t_hi[a])
		);
	end

	rbsi_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_d[DIV_LAT-1]),
		.t_lo    (t_lo),
		.t_hi    (t_hi),
		.side    (side_s[DIV_LAT-1]),
		.out_vld (red_vld),
		.hit     (red_hit),
		.t       (red_t),
		.axd     (red_axd)
	);

	// Hit point per axis.
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_point
		rbsi_point #(.FRAC_BITS(FRAC_BITS)) u_point (
			.clk   (clk),
			.hit   (red_hit),
			.t     (red_t),
			.org   (red_axd.org[a]),
			.dmag  (red_axd.dmag[a]),
			.dneg  (red_axd.dneg[a]),
			.point (pt[a])
		);
	end

	// Valid and hit follow the point stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= '0;
		end else begin
			vld_p <= {vld_p[1:0], red_vld};
		end
	end

	always_ff @(posedge clk) begin
		hit_p <= {hit_p[1:0], red_hit};
	end

	assign done           = vld_p[2];
	assign result.hit     = hit_p[2];
	assign result.point_x = pt[0];
	assign result.point_y = pt[1];
	assign result.point_z = pt[2];

`ifndef SYNTHESIS
	// A result appears only for a matching earlier ray transfer.
	a_done_has_ray: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching ray transfer");

	// A transferred ray always produces its result after the latency.
	a_ray_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy, LAT) && $past(arst_n, LAT) |-> done)
		else $error("ray transfer lost in the pipeline");

	// A miss carries a zero point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit |->
			(result.point_x == '0) && (result.point_y == '0) && (result.point_z == '0))
		else $error("miss with a nonzero point");

	// A ray with no direction that hits reports its own origin.
	a_still_ray: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit && $past(ray.dir_x == '0 && ray.dir_y == '0
			&& ray.dir_z == '0, LAT) |->
			(result.point_x == $past(ray.origin_x, LAT)) &&
			(result.point_y == $past(ray.origin_y, LAT)) &&
			(result.point_z == $past(ray.origin_z, LAT)))
		else $error("zero-direction hit does not return the origin");
`endif

endmodule

`default_nettype wire
